// ----- rtl/core/urc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// urc_pkg
// Types and constants for the ultrasonic range controller.
// ---------------------------------------------------------------------------
package urc_pkg;

   // register map, index is paddr[3:2]
   localparam int unsigned PADDR_W = 4;
   localparam logic [1:0] REG_INTERVAL   = 2'd0;
   localparam logic [1:0] REG_TRIGGER    = 2'd1;
   localparam logic [1:0] REG_ECHO_WAIT  = 2'd2;
   localparam logic [1:0] REG_MAX_TRAVEL = 2'd3;

   localparam int unsigned INTERVAL_W   = 20;
   localparam int unsigned TRIGGER_W    = 8;
   localparam int unsigned ECHO_WAIT_W  = 16;
   localparam int unsigned MAX_TRAVEL_W = 16;

   localparam logic [INTERVAL_W-1:0]   INTERVAL_RST   = 20'd50000;
   localparam logic [TRIGGER_W-1:0]    TRIGGER_RST    = 8'd20;
   localparam logic [ECHO_WAIT_W-1:0]  ECHO_WAIT_RST  = 16'd1000;
   localparam logic [MAX_TRAVEL_W-1:0] MAX_TRAVEL_RST = 16'd23200;

   // result status codes
   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_DISTANCE = 2'd1;
   localparam logic [1:0] ST_NO_ECHO  = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam int unsigned TICK_W = 20;
   localparam int unsigned LEN_W  = 17;
   localparam int unsigned DIST_W = 19;
   localparam int unsigned REM_W  = 5;

   // distance = floor(len * 128 / 29), tracked incrementally:
   // each echo tick adds 128 = 4 * 29 + 12
   localparam logic [REM_W:0]    DIST_DIV  = 6'd29;
   localparam logic [DIST_W-1:0] DIST_STEP = 19'd4;
   localparam logic [REM_W:0]    REM_STEP  = 6'd12;

   typedef struct packed {
      logic [INTERVAL_W-1:0]   interval_ticks;
      logic [TRIGGER_W-1:0]    trigger_ticks;
      logic [ECHO_WAIT_W-1:0]  echo_wait_ticks;
      logic [MAX_TRAVEL_W-1:0] max_travel_ticks;
   } cfg_type;

   typedef struct packed {
      logic              trigger_level;
      logic [1:0]        status;
      logic [DIST_W-1:0] distance_q8;
   } rsp_type;

endpackage : urc_pkg
`default_nettype wire

// ----- rtl/core/ultrasonic_range_controller_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ultrasonic_range_controller_unit
// Echo-ranging sequencer: trigger pulse, echo wait with timeout, echo-high
// measurement, distance in 1/256 cm, idle interval between attempts.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  req      | in        | req_valid/req_ready | req_echo_level (one tick per beat)
//  rsp      | out       | rsp_valid/rsp_ready | rsp_trigger_level, rsp_status,
//           |           |                     | rsp_distance_q8
//  csr      | in/out    | psel/penable, pready| paddr, pwdata, pwrite, prdata
//
// one tick beat per clock while req_ready is high; state updates on the accepting edge
// the result is registered in the output register, or in the skid entry on a stall
// a skid entry behind the output register keeps req_ready high for one extra beat
// while the consumer stalls; req_ready drops only when both entries are full
// reset (synchronous, active high) returns to the trigger phase with zero counts
// and restores the register defaults
// ---------------------------------------------------------------------------
module ultrasonic_range_controller_unit
   import urc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // tick input
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_echo_level,
   // result output
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_trigger_level,
   output      logic [1:0]          rsp_status,
   output      logic [DIST_W-1:0]   rsp_distance_q8,
   // register port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [31:0]         pwdata,
   output      logic [31:0]         prdata,
   output      logic                pready
);

   typedef enum logic [1:0] {
      PH_TRIGGER,
      PH_WAIT,
      PH_MEASURE,
      PH_IDLE
   } phase_type;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   cfg_type cfg_ff;
   logic    csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ticks   <= INTERVAL_RST;
         cfg_ff.trigger_ticks    <= TRIGGER_RST;
         cfg_ff.echo_wait_ticks  <= ECHO_WAIT_RST;
         cfg_ff.max_travel_ticks <= MAX_TRAVEL_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_INTERVAL:   cfg_ff.interval_ticks   <= pwdata[INTERVAL_W-1:0];
            REG_TRIGGER:    cfg_ff.trigger_ticks    <= pwdata[TRIGGER_W-1:0];
            REG_ECHO_WAIT:  cfg_ff.echo_wait_ticks  <= pwdata[ECHO_WAIT_W-1:0];
            REG_MAX_TRAVEL: cfg_ff.max_travel_ticks <= pwdata[MAX_TRAVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback, zero extended
   always_comb begin
      case (paddr[3:2])
         REG_INTERVAL:   prdata = {{(32-INTERVAL_W){1'b0}}, cfg_ff.interval_ticks};
         REG_TRIGGER:    prdata = {{(32-TRIGGER_W){1'b0}}, cfg_ff.trigger_ticks};
         REG_ECHO_WAIT:  prdata = {{(32-ECHO_WAIT_W){1'b0}}, cfg_ff.echo_wait_ticks};
         REG_MAX_TRAVEL: prdata = {{(32-MAX_TRAVEL_W){1'b0}}, cfg_ff.max_travel_ticks};
         default:        prdata = '0;
      endcase
   end

   // a zero interval, trigger or echo-wait register behaves as one
   logic [TICK_W-1:0] interval_lim;
   logic [TICK_W-1:0] trigger_lim;
   logic [TICK_W-1:0] echo_wait_lim;

   assign interval_lim  = (cfg_ff.interval_ticks == '0) ? TICK_W'(1)
                                                        : cfg_ff.interval_ticks;
   assign trigger_lim   = (cfg_ff.trigger_ticks == '0) ? TICK_W'(1)
                          : {{(TICK_W-TRIGGER_W){1'b0}}, cfg_ff.trigger_ticks};
   assign echo_wait_lim = (cfg_ff.echo_wait_ticks == '0) ? TICK_W'(1)
                          : {{(TICK_W-ECHO_WAIT_W){1'b0}}, cfg_ff.echo_wait_ticks};

   // ------------------------------------------------------------------------
   // sequencer state
   // ------------------------------------------------------------------------
   phase_type          phase_ff,        phase_in;
   logic [TICK_W-1:0]  tick_count_ff,   tick_count_in;
   logic [LEN_W-1:0]   echo_length_ff,  echo_length_in;
   logic [DIST_W-1:0]  dist_acc_ff,     dist_acc_in;     // floor(len*128/29)
   logic [REM_W-1:0]   dist_rem_ff,     dist_rem_in;     // (len*128) mod 29
   logic [DIST_W-1:0]  last_distance_ff, last_distance_in;

   logic               req_fire;
   rsp_type            rsp_new;

   logic [TICK_W-1:0]  tick_inc;
   logic [LEN_W-1:0]   len_inc;
   logic               len_over;
   logic [REM_W:0]     rem_sum;
   logic               rem_wrap;
   logic [REM_W:0]     rem_fix;
   logic [DIST_W-1:0]  dist_next;
   logic [LEN_W-1:0]   max_travel_ext;

   assign req_fire       = req_valid & req_ready;
   assign tick_inc       = tick_count_ff + TICK_W'(1);
   assign len_inc        = echo_length_ff + LEN_W'(1);
   assign max_travel_ext = {{(LEN_W-MAX_TRAVEL_W){1'b0}}, cfg_ff.max_travel_ticks};
   assign len_over       = len_inc > max_travel_ext;

   // one more echo tick: add 128/29 as quotient 4, remainder 12, with carry
   assign rem_sum   = {1'b0, dist_rem_ff} + REM_STEP;
   assign rem_wrap  = rem_sum >= DIST_DIV;
   assign rem_fix   = rem_wrap ? (rem_sum - DIST_DIV) : rem_sum;
   assign dist_next = dist_acc_ff + DIST_STEP + DIST_W'(rem_wrap);

   always_comb begin
      phase_in         = phase_ff;
      tick_count_in    = tick_count_ff;
      echo_length_in   = echo_length_ff;
      dist_acc_in      = dist_acc_ff;
      dist_rem_in      = dist_rem_ff;
      last_distance_in = last_distance_ff;
      rsp_new.trigger_level = 1'b0;
      rsp_new.status        = ST_NONE;

      case (phase_ff)
         PH_WAIT: begin
            if (req_echo_level) begin
               // rising echo is the first counted tick
               echo_length_in = LEN_W'(1);
               dist_acc_in    = DIST_STEP;
               dist_rem_in    = REM_STEP[REM_W-1:0];
               if (cfg_ff.max_travel_ticks == '0) begin
                  rsp_new.status = ST_RANGE;
                  phase_in       = PH_IDLE;
                  tick_count_in  = '0;
               end else begin
                  phase_in = PH_MEASURE;
               end
            end else begin
               tick_count_in = tick_inc;
               if (tick_inc >= echo_wait_lim) begin
                  rsp_new.status = ST_NO_ECHO;
                  phase_in       = PH_IDLE;
                  tick_count_in  = '0;
               end
            end
         end
         PH_MEASURE: begin
            if (req_echo_level) begin
               echo_length_in = len_inc;
               dist_acc_in    = dist_next;
               dist_rem_in    = rem_fix[REM_W-1:0];
               if (len_over) begin
                  rsp_new.status = ST_RANGE;
                  phase_in       = PH_IDLE;
                  tick_count_in  = '0;
               end
            end else begin
               // falling echo: report only a changed distance
               if (echo_length_ff != '0 && dist_acc_ff != last_distance_ff) begin
                  last_distance_in = dist_acc_ff;
                  rsp_new.status   = ST_DISTANCE;
               end
               phase_in      = PH_IDLE;
               tick_count_in = '0;
            end
         end
         PH_IDLE: begin
            tick_count_in = tick_inc;
            if (tick_inc >= interval_lim) begin
               phase_in      = PH_TRIGGER;
               tick_count_in = '0;
            end
         end
         default: begin
            // trigger phase: drive the pin, ignore the echo
            rsp_new.trigger_level = 1'b1;
            tick_count_in         = tick_inc;
            if (tick_inc >= trigger_lim) begin
               phase_in       = PH_WAIT;
               tick_count_in  = '0;
               echo_length_in = '0;
               dist_acc_in    = '0;
               dist_rem_in    = '0;
            end
         end
      endcase

      rsp_new.distance_q8 = last_distance_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_TRIGGER;
         tick_count_ff    <= '0;
         echo_length_ff   <= '0;
         dist_acc_ff      <= '0;
         dist_rem_ff      <= '0;
         last_distance_ff <= '0;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         tick_count_ff    <= tick_count_in;
         echo_length_ff   <= echo_length_in;
         dist_acc_ff      <= dist_acc_in;
         dist_rem_ff      <= dist_rem_in;
         last_distance_ff <= last_distance_in;
      end
   end

   // ------------------------------------------------------------------------
   // output register plus one skid entry
   // ------------------------------------------------------------------------
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_take;
   logic    out_open;

   assign req_ready = ~skid_valid_ff;
   assign out_take  = out_valid_ff & rsp_ready;
   assign out_open  = ~out_valid_ff | out_take;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_open) begin
         if (skid_valid_ff) begin
            // drain the skid entry; no new beat can arrive while it is full
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = rsp_new;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         // consumer stalled: park the beat in the skid entry
         skid_data_in  = rsp_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_level = out_data_ff.trigger_level;
   assign rsp_status        = out_data_ff.status;
   assign rsp_distance_q8   = out_data_ff.distance_q8;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // the skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output beat");

   // a trigger tick never carries a measurement status
   a_trigger_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.trigger_level) |-> (out_data_ff.status == ST_NONE))
      else $error("trigger beat with nonzero status");

   // stored distance only moves on a beat taken in the measure phase
   a_distance_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff != PH_MEASURE) |=> $stable(last_distance_ff))
      else $error("distance changed outside measure phase");

   // incremental divide remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, dist_rem_ff} < DIST_DIV)
      else $error("distance remainder out of range");

endmodule : ultrasonic_range_controller_unit
`default_nettype wire

// ----- dv/tb_ultrasonic_range_controller_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ultrasonic_range_controller_unit
// Self-checking bench for the echo-ranging sequencer. A cycle-level predictor
// follows every accepted tick beat and queues the result it should cause; a
// monitor compares each result beat field by field. Directed tests cover the
// register defaults, echo timeout, out-of-range echoes, repeated distances,
// trigger widths, idle intervals and echoes at the travel limit; a random test
// then mixes well-formed echo pulses, noise and register changes under random
// sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb_ultrasonic_range_controller_unit;
   import urc_pkg::*;

   // timing and run-length knobs
   localparam int unsigned CLK_HALF     = 10;
   localparam int unsigned RESET_CYCLES = 8;
   localparam int unsigned STUCK_LIMIT  = 2000;   // cycles with no beat before giving up
   localparam int unsigned DRAIN_CYCLES = 10;     // extra cycles after the last result
   localparam int unsigned RANDOM_BEATS = 220;    // tick beats in the random test
   localparam int unsigned REPORT_CAP   = 40;     // keep the log short if everything breaks

   // distance scaling: d = floor(len * 256 / 58)
   localparam longint unsigned Q8_SCALE       = 256;
   localparam longint unsigned ECHO_US_PER_CM = 58;

   // predictor phases, any unused code acts as the trigger phase
   typedef enum logic [2:0] {
      RNG_TRIGGER = 3'd0,
      RNG_WAIT    = 3'd1,
      RNG_MEASURE = 3'd2,
      RNG_IDLE    = 3'd3
   } ranger_phase_e;

   // receiver stall patterns
   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_PERIODIC,
      RDY_BURSTY
   } ready_mode_e;

   // ------------------------------------------------------------------------
   // dut signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_echo_level = 1'b0;
   logic              rsp_ready      = 1'b0;
   logic              psel           = 1'b0;
   logic              penable        = 1'b0;
   logic              pwrite         = 1'b0;
   logic [PADDR_W-1:0] paddr         = '0;
   logic [31:0]       pwdata         = '0;
   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_trigger_level;
   logic [1:0]        rsp_status;
   logic [DIST_W-1:0] rsp_distance_q8;
   logic [31:0]       prdata;
   logic              pready;

   ultrasonic_range_controller_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_level    (req_echo_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_status        (rsp_status),
      .rsp_distance_q8   (rsp_distance_q8),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 20 ns clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor state: its own copy of the registers and the sequencer
   // ------------------------------------------------------------------------
   cfg_type            ranger_cfg;
   ranger_phase_e      rng_phase;
   logic [TICK_W-1:0]  rng_ticks;
   logic [LEN_W-1:0]   rng_len;
   logic [DIST_W-1:0]  rng_dist;

   // results still owed by the dut, oldest first
   rsp_type            expected_q[$];

   // bookkeeping
   int unsigned fail_count  = 0;
   int unsigned sent_beats  = 0;
   int unsigned echo_beats  = 0;
   int unsigned csr_writes  = 0;
   int unsigned seen_dist   = 0;
   int unsigned seen_noecho = 0;
   int unsigned seen_range  = 0;

   // sender burst state
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   bit          valid_up   = 1'b0;

   // zero in a count register behaves as one
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   // one tick of the sequencer: update state, give back the result it causes
   task automatic advance_ranger(input logic echo, output rsp_type res);
      logic             trig;
      logic [1:0]       st;
      longint unsigned  prod;
      logic [DIST_W-1:0] d;
      trig = 1'b0;
      st   = ST_NONE;
      case (rng_phase)
         RNG_WAIT: begin
            if (echo) begin
               // rising echo counts as the first echo tick
               rng_len = LEN_W'(1);
               if (rng_len > LEN_W'(ranger_cfg.max_travel_ticks)) begin
                  st        = ST_RANGE;
                  rng_phase = RNG_IDLE;
                  rng_ticks = '0;
               end else begin
                  rng_phase = RNG_MEASURE;
               end
            end else begin
               rng_ticks = rng_ticks + 1'b1;
               if (rng_ticks >= at_least_one(TICK_W'(ranger_cfg.echo_wait_ticks))) begin
                  st        = ST_NO_ECHO;
                  rng_phase = RNG_IDLE;
                  rng_ticks = '0;
               end
            end
         end
         RNG_MEASURE: begin
            if (echo) begin
               rng_len = rng_len + 1'b1;
               if (rng_len > LEN_W'(ranger_cfg.max_travel_ticks)) begin
                  st        = ST_RANGE;
                  rng_phase = RNG_IDLE;
                  rng_ticks = '0;
               end
            end else begin
               // falling echo closes the pulse, report only a changed distance
               prod = longint'(rng_len) * Q8_SCALE;
               d    = DIST_W'(prod / ECHO_US_PER_CM);
               if (rng_len != '0 && d != rng_dist) begin
                  rng_dist = d;
                  st       = ST_DISTANCE;
               end
               rng_phase = RNG_IDLE;
               rng_ticks = '0;
            end
         end
         RNG_IDLE: begin
            rng_ticks = rng_ticks + 1'b1;
            if (rng_ticks >= at_least_one(ranger_cfg.interval_ticks)) begin
               rng_phase = RNG_TRIGGER;
               rng_ticks = '0;
            end
         end
         default: begin
            trig      = 1'b1;
            rng_phase = RNG_TRIGGER;
            rng_ticks = rng_ticks + 1'b1;
            if (rng_ticks >= at_least_one(TICK_W'(ranger_cfg.trigger_ticks))) begin
               rng_phase = RNG_WAIT;
               rng_ticks = '0;
               rng_len   = '0;
            end
         end
      endcase
      res.trigger_level = trig;
      res.status        = st;
      res.distance_q8   = rng_dist;
   endtask

   // ------------------------------------------------------------------------
   // sender: one tick beat per call, entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_tick(input logic echo);
      rsp_type exp;
      if (burst_left == 0) begin
         // mostly short bursts with gaps, now and then a long stretch with none
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 400);
            gap_left   = 0;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 10);
         end
      end
      if (gap_left > 0) begin
         if (valid_up) req_valid <= 1'b0;
         valid_up = 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      req_valid      <= 1'b1;
      req_echo_level <= echo;
      valid_up        = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // beat taken at this edge
      sent_beats++;
      if (rng_phase == RNG_WAIT || rng_phase == RNG_MEASURE) echo_beats++;
      advance_ranger(echo, exp);
      expected_q.push_back(exp);
      burst_left--;
      @(negedge clock);
   endtask

   // stop sending and wait until every owed result has come back
   task automatic hold_off();
      if (valid_up) req_valid <= 1'b0;
      valid_up = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // register port: setup, access, then psel and penable low before another setup cycle
   // ------------------------------------------------------------------------
   task automatic csr_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
      logic [31:0] got;
      csr_xfer(1'b0, idx, '0, got);
      if (got !== want) begin
         fail_count++;
         $error("register %0d read back 0x%08h, expected 0x%08h", idx, got, want);
      end
   endtask

   // drains the block first, then writes the register and reads it back
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      logic [31:0] dummy;
      logic [31:0] kept;
      hold_off();
      csr_xfer(1'b1, idx, data, dummy);
      csr_writes++;
      case (idx)
         REG_INTERVAL: begin
            ranger_cfg.interval_ticks = data[INTERVAL_W-1:0];
            kept = 32'(data[INTERVAL_W-1:0]);
         end
         REG_TRIGGER: begin
            ranger_cfg.trigger_ticks = data[TRIGGER_W-1:0];
            kept = 32'(data[TRIGGER_W-1:0]);
         end
         REG_ECHO_WAIT: begin
            ranger_cfg.echo_wait_ticks = data[ECHO_WAIT_W-1:0];
            kept = 32'(data[ECHO_WAIT_W-1:0]);
         end
         default: begin
            ranger_cfg.max_travel_ticks = data[MAX_TRAVEL_W-1:0];
            kept = 32'(data[MAX_TRAVEL_W-1:0]);
         end
      endcase
      check_reg(idx, kept);
   endtask

   // ------------------------------------------------------------------------
   // one ranging attempt: let trigger/idle run out with junk on the echo pin,
   // then some low samples, a high pulse and the falling edge
   // ------------------------------------------------------------------------
   task automatic run_attempt(input int unsigned lows, input int unsigned highs);
      int unsigned i;
      while (rng_phase != RNG_WAIT) send_tick(1'($urandom_range(0, 1)));
      for (i = 0; i < lows && rng_phase == RNG_WAIT; i++) send_tick(1'b0);
      for (i = 0; i < highs && rng_phase != RNG_IDLE; i++) send_tick(1'b1);
      if (rng_phase == RNG_MEASURE) send_tick(1'b0);
   endtask

   // ------------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------------

   // register defaults after reset, then one attempt at the default settings
   task automatic test_reset_defaults();
      check_reg(REG_INTERVAL, 32'(INTERVAL_RST));
      check_reg(REG_TRIGGER, 32'(TRIGGER_RST));
      check_reg(REG_ECHO_WAIT, 32'(ECHO_WAIT_RST));
      check_reg(REG_MAX_TRAVEL, 32'(MAX_TRAVEL_RST));
      run_attempt(5, 20);
      // cut the long default idle short while sitting in it, and shorten the trigger
      write_reg(REG_INTERVAL, 32'd2);
      write_reg(REG_TRIGGER, 32'd2);
   endtask

   // echo never rises: timeout at a short limit, at zero (acts as one), at one,
   // and a pulse that starts one sample before the limit
   task automatic test_no_echo_timeout();
      write_reg(REG_ECHO_WAIT, 32'd8);
      run_attempt(8, 0);
      write_reg(REG_ECHO_WAIT, 32'hA5A5_0000);   // upper bits dropped, field reads zero
      run_attempt(3, 0);
      write_reg(REG_ECHO_WAIT, 32'd1);
      run_attempt(1, 0);
      write_reg(REG_ECHO_WAIT, 32'd4);
      run_attempt(3, 5);
      run_attempt(4, 0);
   endtask

   // echo longer than the max travel time, including a zero limit
   task automatic test_out_of_range();
      write_reg(REG_MAX_TRAVEL, 32'd1);
      run_attempt(0, 1);
      run_attempt(0, 2);
      write_reg(REG_MAX_TRAVEL, 32'd0);
      run_attempt(2, 1);
      write_reg(REG_MAX_TRAVEL, 32'd5);
      run_attempt(0, 5);
      run_attempt(0, 6);
   endtask

   // the same distance twice gives no report the second time
   task automatic test_repeated_distance();
      write_reg(REG_MAX_TRAVEL, 32'd200);
      run_attempt(1, 12);
      run_attempt(2, 12);
      run_attempt(0, 13);
   endtask

   // trigger field with upper bits dropped, zero and one-tick trigger pulses
   task automatic test_trigger_width();
      write_reg(REG_TRIGGER, 32'h103);
      run_attempt(0, 3);
      write_reg(REG_TRIGGER, 32'd0);
      run_attempt(0, 3);
      write_reg(REG_TRIGGER, 32'd1);
      run_attempt(1, 4);
      write_reg(REG_TRIGGER, 32'd2);
   endtask

   // an interval near the field maximum, then shrink it to zero while already past it
   task automatic test_idle_interval();
      run_attempt(0, 0);                          // park in the wait phase
      write_reg(REG_INTERVAL, 32'd1000000);
      run_attempt(2, 10);
      repeat (20) send_tick(1'($urandom_range(0, 1)));
      write_reg(REG_INTERVAL, 32'd0);
      run_attempt(1, 7);
      run_attempt(1, 8);
      write_reg(REG_INTERVAL, 32'd3);
   endtask

   // echo exactly at the travel limit and one tick past it, widest echo wait
   task automatic test_longest_echo();
      write_reg(REG_ECHO_WAIT, 32'd65535);
      write_reg(REG_MAX_TRAVEL, 32'd22);
      run_attempt(3, 22);
      run_attempt(3, 23);
      write_reg(REG_ECHO_WAIT, 32'd10);
      write_reg(REG_MAX_TRAVEL, 32'd30);
   endtask

   // ------------------------------------------------------------------------
   // random test: mostly well-formed pulses near the thresholds, some noise,
   // some register changes and a few full drains
   // ------------------------------------------------------------------------
   task automatic test_random_ticks();
      int unsigned start;
      int unsigned ew;
      int unsigned mt;
      start = sent_beats;
      while (sent_beats - start < RANDOM_BEATS) begin
         case ($urandom_range(0, 9))
            0: begin
               write_reg(REG_INTERVAL, ($urandom_range(0, 7) == 0) ?
                         $urandom_range(0, 60) : $urandom_range(0, 4));
               write_reg(REG_TRIGGER, ($urandom_range(0, 15) == 0) ?
                         $urandom_range(0, 40) : $urandom_range(0, 3));
               write_reg(REG_ECHO_WAIT, $urandom_range(0, 12));
               write_reg(REG_MAX_TRAVEL, ($urandom_range(0, 9) == 0) ?
                         $urandom_range(0, 60) : $urandom_range(0, 16));
            end
            1: repeat ($urandom_range(5, 30)) send_tick(1'($urandom_range(0, 1)));
            2: hold_off();
            default: begin
               ew = at_least_one(TICK_W'(ranger_cfg.echo_wait_ticks));
               mt = ranger_cfg.max_travel_ticks;
               run_attempt($urandom_range(0, ew + 2), $urandom_range(1, mt + 2));
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   task automatic field_mismatch(input string name, input longint unsigned want,
                                 input longint unsigned got);
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_status)
            ST_DISTANCE: seen_dist++;
            ST_NO_ECHO:  seen_noecho++;
            ST_RANGE:    seen_range++;
            default: ;
         endcase
         if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP) $error("result beat with nothing expected");
         end else begin
            exp = expected_q.pop_front();
            if (rsp_trigger_level !== exp.trigger_level)
               field_mismatch("trigger_level", exp.trigger_level, rsp_trigger_level);
            if (rsp_status !== exp.status)
               field_mismatch("status", exp.status, rsp_status);
            if (rsp_distance_q8 !== exp.distance_q8)
               field_mismatch("distance_q8", exp.distance_q8, rsp_distance_q8);
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: rsp_ready follows a pattern that is picked anew at random -
   // always ready, coin flip, periodic stall, or long stalls
   // ------------------------------------------------------------------------
   ready_mode_e ready_mode = RDY_ALWAYS;
   int unsigned mode_left  = 0;
   int unsigned stall_left = 0;

   always @(negedge clock) begin
      logic ready_next;
      if (mode_left == 0) begin
         ready_mode = ready_mode_e'($urandom_range(0, 3));
         mode_left  = $urandom_range(50, 400);
         stall_left = 0;
      end else begin
         mode_left--;
      end
      case (ready_mode)
         RDY_ALWAYS:   ready_next = 1'b1;
         RDY_COIN:     ready_next = 1'($urandom_range(0, 1));
         RDY_PERIODIC: ready_next = (mode_left % 4) != 0;
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
               if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 40);
            end
         end
      endcase
      rsp_ready <= ready_next;
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any beat on any channel means a hang
   // ------------------------------------------------------------------------
   int unsigned stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  stuck_cycles, expected_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      // predictor starts from the reset state
      ranger_cfg.interval_ticks   = INTERVAL_RST;
      ranger_cfg.trigger_ticks    = TRIGGER_RST;
      ranger_cfg.echo_wait_ticks  = ECHO_WAIT_RST;
      ranger_cfg.max_travel_ticks = MAX_TRAVEL_RST;
      rng_phase = RNG_TRIGGER;
      rng_ticks = '0;
      rng_len   = '0;
      rng_dist  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_no_echo_timeout();
      test_out_of_range();
      test_repeated_distance();
      test_trigger_width();
      test_idle_interval();
      test_longest_echo();
      test_random_ticks();

      // drain, then give any stray result time to show up
      hold_off();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_q.size() != 0) begin
         fail_count++;
         $error("%0d results never arrived", expected_q.size());
      end

      $display("run: %0d tick beats (%0d during echo wait or measure), %0d register writes",
               sent_beats, echo_beats, csr_writes);
      $display("results seen: %0d new distances, %0d echo timeouts, %0d out of range",
               seen_dist, seen_noecho, seen_range);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule : tb_ultrasonic_range_controller_unit

// ----- ultrasonic_range_controller_unit.f -----
rtl/core/urc_pkg.sv
rtl/core/ultrasonic_range_controller_unit.sv
dv/tb_ultrasonic_range_controller_unit.sv
